// ----- rtl/kbs_pkg.sv -----
// Shared types, constants and the key translation ROM for the scancode block.
package kbs_pkg;

  // Set-1 modifier and prefix codes
  localparam logic [7:0] CODE_ALT   = 8'h38;
  localparam logic [7:0] CODE_CTRL  = 8'h1D;
  localparam logic [7:0] CODE_SHIFT = 8'h2A;
  localparam logic [7:0] CODE_E0    = 8'hE0;

  // Sticky toggle bytes
  localparam logic [7:0] BYTE_NONE         = 8'h00;
  localparam logic [7:0] BYTE_ALT_TOGGLE   = 8'hA6;
  localparam logic [7:0] BYTE_CTRL_TOGGLE  = 8'hA7;
  localparam logic [7:0] BYTE_SHIFT_TOGGLE = 8'hA8;

  // Flag bit positions in a ROM entry
  localparam int unsigned FLAG_SHIFT = 0;
  localparam int unsigned FLAG_E0    = 1;
  localparam int unsigned FLAG_ALT   = 2;
  localparam int unsigned FLAG_CTRL  = 3;

  // Output slots of one command, in emission order
  localparam int unsigned NSLOT          = 7;
  localparam int unsigned SLOT_REL_PFX   = 0;
  localparam int unsigned SLOT_REL_CODE  = 1;
  localparam int unsigned SLOT_CLR_ALT   = 2;
  localparam int unsigned SLOT_CLR_CTRL  = 3;
  localparam int unsigned SLOT_CLR_SHIFT = 4;
  localparam int unsigned SLOT_NEW_PFX   = 5;
  localparam int unsigned SLOT_NEW_CODE  = 6;

  // Command queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [NSLOT-1:0] mask;
    logic [7:0]       rel_pfx;
    logic [7:0]       rel_code;
    logic [7:0]       new_pfx;
    logic [7:0]       new_code;
    logic             new_down;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] code;
    logic [3:0] flags;
  } rom_ent_t;

  // Prefix code for a flag set; ROM entries carry at most one flag
  function automatic logic [7:0] pfx_code(input logic [3:0] flags);
    logic [7:0] c;
    c = CODE_CTRL;
    if (flags[FLAG_SHIFT])     c = CODE_SHIFT;
    else if (flags[FLAG_E0])   c = CODE_E0;
    else if (flags[FLAG_ALT])  c = CODE_ALT;
    return c;
  endfunction

  function automatic rom_ent_t rom_lookup(input logic [7:0] b);
    rom_ent_t r;
    r = '{hit: 1'b1, code: 8'h00, flags: 4'h0};
    case (b)
      8'h1B: r.code = 8'h01;  8'h0D: r.code = 8'h1C;  8'h20: r.code = 8'h39;
      8'h08: r.code = 8'h0E;  8'h09: r.code = 8'h0F;
      8'h31: r.code = 8'h02;  8'h32: r.code = 8'h03;  8'h33: r.code = 8'h04;
      8'h34: r.code = 8'h05;  8'h35: r.code = 8'h06;  8'h36: r.code = 8'h07;
      8'h37: r.code = 8'h08;  8'h38: r.code = 8'h09;  8'h39: r.code = 8'h0A;
      8'h30: r.code = 8'h0B;
      8'h71: r.code = 8'h10;  8'h77: r.code = 8'h11;  8'h65: r.code = 8'h12;
      8'h72: r.code = 8'h13;  8'h74: r.code = 8'h14;  8'h79: r.code = 8'h15;
      8'h75: r.code = 8'h16;  8'h69: r.code = 8'h17;  8'h6F: r.code = 8'h18;
      8'h70: r.code = 8'h19;
      8'h61: r.code = 8'h1E;  8'h73: r.code = 8'h1F;  8'h64: r.code = 8'h20;
      8'h66: r.code = 8'h21;  8'h67: r.code = 8'h22;  8'h68: r.code = 8'h23;
      8'h6A: r.code = 8'h24;  8'h6B: r.code = 8'h25;  8'h6C: r.code = 8'h26;
      8'h7A: r.code = 8'h2C;  8'h78: r.code = 8'h2D;  8'h63: r.code = 8'h2E;
      8'h76: r.code = 8'h2F;  8'h62: r.code = 8'h30;  8'h6E: r.code = 8'h31;
      8'h6D: r.code = 8'h32;  8'h2C: r.code = 8'h33;  8'h2E: r.code = 8'h34;
      8'h51: r = '{1'b1, 8'h10, 4'h1};  8'h57: r = '{1'b1, 8'h11, 4'h1};
      8'h45: r = '{1'b1, 8'h12, 4'h1};  8'h52: r = '{1'b1, 8'h13, 4'h1};
      8'h54: r = '{1'b1, 8'h14, 4'h1};  8'h59: r = '{1'b1, 8'h15, 4'h1};
      8'h55: r = '{1'b1, 8'h16, 4'h1};  8'h49: r = '{1'b1, 8'h17, 4'h1};
      8'h4F: r = '{1'b1, 8'h18, 4'h1};  8'h50: r = '{1'b1, 8'h19, 4'h1};
      8'h41: r = '{1'b1, 8'h1E, 4'h1};  8'h53: r = '{1'b1, 8'h1F, 4'h1};
      8'h44: r = '{1'b1, 8'h20, 4'h1};  8'h46: r = '{1'b1, 8'h21, 4'h1};
      8'h47: r = '{1'b1, 8'h22, 4'h1};  8'h48: r = '{1'b1, 8'h23, 4'h1};
      8'h4A: r = '{1'b1, 8'h24, 4'h1};  8'h4B: r = '{1'b1, 8'h25, 4'h1};
      8'h4C: r = '{1'b1, 8'h26, 4'h1};
      8'h5A: r = '{1'b1, 8'h2C, 4'h1};  8'h58: r = '{1'b1, 8'h2D, 4'h1};
      8'h43: r = '{1'b1, 8'h2E, 4'h1};  8'h56: r = '{1'b1, 8'h2F, 4'h1};
      8'h42: r = '{1'b1, 8'h30, 4'h1};  8'h4E: r = '{1'b1, 8'h31, 4'h1};
      8'h4D: r = '{1'b1, 8'h32, 4'h1};
      8'h21: r = '{1'b1, 8'h02, 4'h1};  8'h40: r = '{1'b1, 8'h03, 4'h1};
      8'h23: r = '{1'b1, 8'h04, 4'h1};  8'h24: r = '{1'b1, 8'h05, 4'h1};
      8'h25: r = '{1'b1, 8'h06, 4'h1};  8'h5E: r = '{1'b1, 8'h07, 4'h1};
      8'h26: r = '{1'b1, 8'h08, 4'h1};  8'h2A: r = '{1'b1, 8'h09, 4'h1};
      8'h28: r = '{1'b1, 8'h0A, 4'h1};  8'h29: r = '{1'b1, 8'h0B, 4'h1};
      8'h7B: r = '{1'b1, 8'h1A, 4'h1};  8'h7D: r = '{1'b1, 8'h1B, 4'h1};
      8'h5B: r.code = 8'h1A;  8'h5D: r.code = 8'h1B;  8'h2F: r.code = 8'h35;
      8'h5C: r.code = 8'h2B;
      8'h7C: r = '{1'b1, 8'h2B, 4'h1};  8'h7E: r = '{1'b1, 8'h29, 4'h1};
      8'h27: r.code = 8'h28;
      8'h22: r = '{1'b1, 8'h28, 4'h1};
      8'h3B: r.code = 8'h27;
      8'h3A: r = '{1'b1, 8'h27, 4'h1};
      8'h60: r.code = 8'h29;
      8'h2B: r = '{1'b1, 8'h0D, 4'h1};
      8'h2D: r.code = 8'h0C;
      8'h5F: r = '{1'b1, 8'h0C, 4'h1};
      8'h3D: r.code = 8'h0D;
      8'h3F: r = '{1'b1, 8'h35, 4'h1};  8'h3C: r = '{1'b1, 8'h33, 4'h1};
      8'h3E: r = '{1'b1, 8'h34, 4'h1};
      8'h81: r.code = 8'h3B;  8'h82: r.code = 8'h3C;  8'h83: r.code = 8'h3D;
      8'h84: r.code = 8'h3E;  8'h85: r.code = 8'h3F;  8'h86: r.code = 8'h40;
      8'h87: r.code = 8'h41;  8'h88: r.code = 8'h42;  8'h89: r.code = 8'h43;
      8'h8A: r.code = 8'h44;
      8'hB5: r = '{1'b1, 8'h48, 4'h2};  8'hB6: r = '{1'b1, 8'h50, 4'h2};
      8'hB4: r = '{1'b1, 8'h4B, 4'h2};  8'hB7: r = '{1'b1, 8'h4D, 4'h2};
      8'h99: r = '{1'b1, 8'h49, 4'h2};  8'hA4: r = '{1'b1, 8'h51, 4'h2};
      8'h98: r = '{1'b1, 8'h47, 4'h2};  8'hA5: r = '{1'b1, 8'h4F, 4'h2};
      8'h8B: r = '{1'b1, 8'h53, 4'h2};
      8'h8D: r = '{1'b1, 8'h3E, 4'h4};  8'h8E: r = '{1'b1, 8'h3E, 4'h8};
      default: r = '{1'b0, 8'h00, 4'h0};
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/kbs_front.sv -----
// Front end: holds key and sticky state, turns each byte into a slot command.
module kbs_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      key_byte_i,
  input  kbs_pkg::q_stat_t q_stat_i,
  output logic            push_o,
  output kbs_pkg::cmd_t   cmd_o
);
  import kbs_pkg::*;

  logic       held_valid_q, held_valid_d;
  logic [7:0] held_code_q, held_code_d;
  logic [3:0] held_flags_q, held_flags_d;
  logic       alt_q, alt_d, ctrl_q, ctrl_d, shift_q, shift_d;
  logic       acc;
  logic       alt_c, ctrl_c, shift_c;
  rom_ent_t   ent;

  assign in_ready_o = !q_stat_i.full;
  assign acc        = in_valid_i && in_ready_o;
  assign ent        = rom_lookup(key_byte_i);

  always_comb begin
    cmd_o        = '0;
    held_valid_d = held_valid_q;
    held_code_d  = held_code_q;
    held_flags_d = held_flags_q;

    // release of the held key also drops every sticky toggle
    cmd_o.rel_pfx  = pfx_code(held_flags_q);
    cmd_o.rel_code = held_code_q;
    cmd_o.mask[SLOT_REL_PFX]   = held_valid_q && (held_flags_q != 4'h0);
    cmd_o.mask[SLOT_REL_CODE]  = held_valid_q;
    cmd_o.mask[SLOT_CLR_ALT]   = held_valid_q && alt_q;
    cmd_o.mask[SLOT_CLR_CTRL]  = held_valid_q && ctrl_q;
    cmd_o.mask[SLOT_CLR_SHIFT] = held_valid_q && shift_q;
    alt_c   = alt_q && !held_valid_q;
    ctrl_c  = ctrl_q && !held_valid_q;
    shift_c = shift_q && !held_valid_q;
    alt_d   = alt_c;
    ctrl_d  = ctrl_c;
    shift_d = shift_c;
    if (held_valid_q) begin
      held_valid_d = 1'b0;
      held_code_d  = 8'h00;
      held_flags_d = 4'h0;
    end

    cmd_o.new_pfx = pfx_code(ent.flags);
    if (key_byte_i == BYTE_ALT_TOGGLE) begin
      alt_d = !alt_c;
      cmd_o.mask[SLOT_NEW_CODE] = 1'b1;
      cmd_o.new_code = CODE_ALT;
      cmd_o.new_down = !alt_c;
    end else if (key_byte_i == BYTE_CTRL_TOGGLE) begin
      ctrl_d = !ctrl_c;
      cmd_o.mask[SLOT_NEW_CODE] = 1'b1;
      cmd_o.new_code = CODE_CTRL;
      cmd_o.new_down = !ctrl_c;
    end else if (key_byte_i == BYTE_SHIFT_TOGGLE) begin
      shift_d = !shift_c;
      cmd_o.mask[SLOT_NEW_CODE] = 1'b1;
      cmd_o.new_code = CODE_SHIFT;
      cmd_o.new_down = !shift_c;
    end else if (ent.hit && key_byte_i != BYTE_NONE) begin
      cmd_o.mask[SLOT_NEW_PFX]  = ent.flags != 4'h0;
      cmd_o.mask[SLOT_NEW_CODE] = 1'b1;
      cmd_o.new_code = ent.code;
      cmd_o.new_down = 1'b1;
      held_valid_d   = 1'b1;
      held_code_d    = ent.code;
      held_flags_d   = ent.flags;
    end
  end

  // a word with nothing to send never enters the queue
  assign push_o = acc && (cmd_o.mask != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      held_code_q  <= 8'h00;
      held_flags_q <= 4'h0;
      alt_q        <= 1'b0;
      ctrl_q       <= 1'b0;
      shift_q      <= 1'b0;
    end else if (acc) begin
      held_valid_q <= held_valid_d;
      held_code_q  <= held_code_d;
      held_flags_q <= held_flags_d;
      alt_q        <= alt_d;
      ctrl_q       <= ctrl_d;
      shift_q      <= shift_d;
    end
  end

endmodule

// ----- rtl/kbs_fifo.sv -----
// Short command queue between the front end and the output sequencer.
module kbs_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  kbs_pkg::cmd_t    push_cmd_i,
  input  logic             pop_i,
  output kbs_pkg::cmd_t    pop_cmd_o,
  output kbs_pkg::q_stat_t stat_o
);
  import kbs_pkg::*;

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign stat_o.full  = cnt_q == QCNT_W'(QDEPTH);
  assign stat_o.empty = cnt_q == '0;
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_cmd_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ----- rtl/kbs_back.sv -----
// Back end: walks the slots of one command and sends one code per cycle when not stalled.
module kbs_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  kbs_pkg::cmd_t    cmd_i,
  input  kbs_pkg::q_stat_t q_stat_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             is_down_o,
  output logic [7:0]       keycode_o,
  output logic             last_o
);
  import kbs_pkg::*;

  cmd_t             cur_q;
  logic [NSLOT-1:0] mask_q, mask_d, sel, rem;
  logic             adv, emit, sel_down;
  logic [7:0]       sel_code;
  logic             out_valid_q, is_down_q, last_q;
  logic [7:0]       keycode_q;

  // lowest pending slot goes first
  always_comb begin
    sel = '0;
    for (int i = 0; i < NSLOT; i++) begin
      if (mask_q[i] && sel == '0) sel[i] = 1'b1;
    end
  end

  always_comb begin
    sel_code = cur_q.new_code;
    sel_down = cur_q.new_down;
    if (sel[SLOT_REL_PFX]) begin
      sel_code = cur_q.rel_pfx;   sel_down = 1'b0;
    end else if (sel[SLOT_REL_CODE]) begin
      sel_code = cur_q.rel_code;  sel_down = 1'b0;
    end else if (sel[SLOT_CLR_ALT]) begin
      sel_code = CODE_ALT;        sel_down = 1'b0;
    end else if (sel[SLOT_CLR_CTRL]) begin
      sel_code = CODE_CTRL;       sel_down = 1'b0;
    end else if (sel[SLOT_CLR_SHIFT]) begin
      sel_code = CODE_SHIFT;      sel_down = 1'b0;
    end else if (sel[SLOT_NEW_PFX]) begin
      sel_code = cur_q.new_pfx;   sel_down = 1'b1;
    end
  end

  assign adv   = !out_valid_q || out_ready_i;
  assign emit  = adv && (mask_q != '0);
  assign rem   = mask_q & ~sel;
  assign pop_o = !q_stat_i.empty && ((mask_q == '0) || (emit && rem == '0));

  always_comb begin
    mask_d = mask_q;
    if (emit)  mask_d = rem;
    if (pop_o) mask_d = cmd_i.mask;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= cmd_i;
    if (emit) begin
      is_down_q <= sel_down;
      keycode_q <= sel_code;
      last_q    <= rem == '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q <= mask_d;
      if (adv) out_valid_q <= emit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign is_down_o   = is_down_q;
  assign keycode_o   = keycode_q;
  assign last_o      = last_q;

endmodule

// ----- rtl/key_byte_to_ps2_scancodes.sv -----
// A byte's command is queued when the byte is taken; the output sequencer loads it from
// the queue and registers its codes. Throughput: one code per cycle while the receiver
// is ready; a byte yields 0 to 7 codes, and bytes with none cost the back end nothing.
// The front takes a byte every cycle while the two-entry command queue has room.
// Reset (async, active low) clears the held key, sticky toggles, queue and output.
module key_byte_to_ps2_scancodes (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] key_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       is_down_o,
  output logic [7:0] keycode_o,
  output logic       last_o
);
  import kbs_pkg::*;

  logic    push, pop;
  cmd_t    push_cmd, pop_cmd;
  q_stat_t q_stat;

  kbs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .key_byte_i (key_byte_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  kbs_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd),
    .stat_o     (q_stat)
  );

  kbs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (pop_cmd),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .is_down_o   (is_down_o),
    .keycode_o   (keycode_o),
    .last_o      (last_o)
  );

  a_push_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> push_cmd.mask != '0)
    else $error("empty command pushed");

  a_q_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue both full and empty");

  a_code_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> keycode_o != 8'h00)
    else $error("zero keycode sent");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.full |-> !push)
    else $error("push into full queue");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for key_byte_to_ps2_scancodes: directed and random key bytes.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kbs_pkg::*;

  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned TAIL_CYCLES = 12;

  // {hit, flags} for each kind of key in the translation map
  localparam logic [4:0] K_PLAIN = 5'b10000;
  localparam logic [4:0] K_SHIFT = K_PLAIN | (5'd1 << FLAG_SHIFT);
  localparam logic [4:0] K_EXT   = K_PLAIN | (5'd1 << FLAG_E0);
  localparam logic [4:0] K_ALT   = K_PLAIN | (5'd1 << FLAG_ALT);
  localparam logic [4:0] K_CTRL  = K_PLAIN | (5'd1 << FLAG_CTRL);

  typedef struct packed {
    logic       hit;
    logic [3:0] flags;
    logic [7:0] code;
  } key_entry_t;

  typedef struct packed {
    logic       is_down;
    logic [7:0] keycode;
    logic       last;
  } scancode_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] key_byte_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       is_down_o;
  logic [7:0] keycode_o;
  logic       last_o;

  // predicted keyboard state
  logic       held_valid = 1'b0;
  logic [7:0] held_code = '0;
  logic [3:0] held_flags = '0;
  logic       alt_on = 1'b0;
  logic       ctrl_on = 1'b0;
  logic       shift_on = 1'b0;

  scancode_t   pending_codes[$];
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned sender_burst = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_phase = 0;

  key_byte_to_ps2_scancodes DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .key_byte_i  (key_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .is_down_o   (is_down_o),
    .keycode_o   (keycode_o),
    .last_o      (last_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic key_entry_t key_map(input logic [7:0] b);
    key_entry_t e;
    e = '0;
    case (b)
      8'h1B: e = {K_PLAIN, 8'h01};  8'h0D: e = {K_PLAIN, 8'h1C};  8'h20: e = {K_PLAIN, 8'h39};
      8'h08: e = {K_PLAIN, 8'h0E};  8'h09: e = {K_PLAIN, 8'h0F};  8'h31: e = {K_PLAIN, 8'h02};
      8'h32: e = {K_PLAIN, 8'h03};  8'h33: e = {K_PLAIN, 8'h04};  8'h34: e = {K_PLAIN, 8'h05};
      8'h35: e = {K_PLAIN, 8'h06};  8'h36: e = {K_PLAIN, 8'h07};  8'h37: e = {K_PLAIN, 8'h08};
      8'h38: e = {K_PLAIN, 8'h09};  8'h39: e = {K_PLAIN, 8'h0A};  8'h30: e = {K_PLAIN, 8'h0B};
      8'h71: e = {K_PLAIN, 8'h10};  8'h77: e = {K_PLAIN, 8'h11};  8'h65: e = {K_PLAIN, 8'h12};
      8'h72: e = {K_PLAIN, 8'h13};  8'h74: e = {K_PLAIN, 8'h14};  8'h79: e = {K_PLAIN, 8'h15};
      8'h75: e = {K_PLAIN, 8'h16};  8'h69: e = {K_PLAIN, 8'h17};  8'h6F: e = {K_PLAIN, 8'h18};
      8'h70: e = {K_PLAIN, 8'h19};  8'h61: e = {K_PLAIN, 8'h1E};  8'h73: e = {K_PLAIN, 8'h1F};
      8'h64: e = {K_PLAIN, 8'h20};  8'h66: e = {K_PLAIN, 8'h21};  8'h67: e = {K_PLAIN, 8'h22};
      8'h68: e = {K_PLAIN, 8'h23};  8'h6A: e = {K_PLAIN, 8'h24};  8'h6B: e = {K_PLAIN, 8'h25};
      8'h6C: e = {K_PLAIN, 8'h26};  8'h7A: e = {K_PLAIN, 8'h2C};  8'h78: e = {K_PLAIN, 8'h2D};
      8'h63: e = {K_PLAIN, 8'h2E};  8'h76: e = {K_PLAIN, 8'h2F};  8'h62: e = {K_PLAIN, 8'h30};
      8'h6E: e = {K_PLAIN, 8'h31};  8'h6D: e = {K_PLAIN, 8'h32};  8'h2C: e = {K_PLAIN, 8'h33};
      8'h2E: e = {K_PLAIN, 8'h34};
      8'h51: e = {K_SHIFT, 8'h10};  8'h57: e = {K_SHIFT, 8'h11};  8'h45: e = {K_SHIFT, 8'h12};
      8'h52: e = {K_SHIFT, 8'h13};  8'h54: e = {K_SHIFT, 8'h14};  8'h59: e = {K_SHIFT, 8'h15};
      8'h55: e = {K_SHIFT, 8'h16};  8'h49: e = {K_SHIFT, 8'h17};  8'h4F: e = {K_SHIFT, 8'h18};
      8'h50: e = {K_SHIFT, 8'h19};  8'h41: e = {K_SHIFT, 8'h1E};  8'h53: e = {K_SHIFT, 8'h1F};
      8'h44: e = {K_SHIFT, 8'h20};  8'h46: e = {K_SHIFT, 8'h21};  8'h47: e = {K_SHIFT, 8'h22};
      8'h48: e = {K_SHIFT, 8'h23};  8'h4A: e = {K_SHIFT, 8'h24};  8'h4B: e = {K_SHIFT, 8'h25};
      8'h4C: e = {K_SHIFT, 8'h26};  8'h5A: e = {K_SHIFT, 8'h2C};  8'h58: e = {K_SHIFT, 8'h2D};
      8'h43: e = {K_SHIFT, 8'h2E};  8'h56: e = {K_SHIFT, 8'h2F};  8'h42: e = {K_SHIFT, 8'h30};
      8'h4E: e = {K_SHIFT, 8'h31};  8'h4D: e = {K_SHIFT, 8'h32};
      8'h21: e = {K_SHIFT, 8'h02};  8'h40: e = {K_SHIFT, 8'h03};  8'h23: e = {K_SHIFT, 8'h04};
      8'h24: e = {K_SHIFT, 8'h05};  8'h25: e = {K_SHIFT, 8'h06};  8'h5E: e = {K_SHIFT, 8'h07};
      8'h26: e = {K_SHIFT, 8'h08};  8'h2A: e = {K_SHIFT, 8'h09};  8'h28: e = {K_SHIFT, 8'h0A};
      8'h29: e = {K_SHIFT, 8'h0B};  8'h7B: e = {K_SHIFT, 8'h1A};  8'h7D: e = {K_SHIFT, 8'h1B};
      8'h5B: e = {K_PLAIN, 8'h1A};  8'h5D: e = {K_PLAIN, 8'h1B};  8'h2F: e = {K_PLAIN, 8'h35};
      8'h5C: e = {K_PLAIN, 8'h2B};  8'h7C: e = {K_SHIFT, 8'h2B};  8'h7E: e = {K_SHIFT, 8'h29};
      8'h27: e = {K_PLAIN, 8'h28};  8'h22: e = {K_SHIFT, 8'h28};  8'h3B: e = {K_PLAIN, 8'h27};
      8'h3A: e = {K_SHIFT, 8'h27};  8'h60: e = {K_PLAIN, 8'h29};  8'h2B: e = {K_SHIFT, 8'h0D};
      8'h2D: e = {K_PLAIN, 8'h0C};  8'h5F: e = {K_SHIFT, 8'h0C};  8'h3D: e = {K_PLAIN, 8'h0D};
      8'h3F: e = {K_SHIFT, 8'h35};  8'h3C: e = {K_SHIFT, 8'h33};  8'h3E: e = {K_SHIFT, 8'h34};
      8'h81: e = {K_PLAIN, 8'h3B};  8'h82: e = {K_PLAIN, 8'h3C};  8'h83: e = {K_PLAIN, 8'h3D};
      8'h84: e = {K_PLAIN, 8'h3E};  8'h85: e = {K_PLAIN, 8'h3F};  8'h86: e = {K_PLAIN, 8'h40};
      8'h87: e = {K_PLAIN, 8'h41};  8'h88: e = {K_PLAIN, 8'h42};  8'h89: e = {K_PLAIN, 8'h43};
      8'h8A: e = {K_PLAIN, 8'h44};
      8'hB5: e = {K_EXT, 8'h48};    8'hB6: e = {K_EXT, 8'h50};    8'hB4: e = {K_EXT, 8'h4B};
      8'hB7: e = {K_EXT, 8'h4D};    8'h99: e = {K_EXT, 8'h49};    8'hA4: e = {K_EXT, 8'h51};
      8'h98: e = {K_EXT, 8'h47};    8'hA5: e = {K_EXT, 8'h4F};    8'h8B: e = {K_EXT, 8'h53};
      8'h8D: e = {K_ALT, 8'h3E};    8'h8E: e = {K_CTRL, 8'h3E};
      default: e = '0;
    endcase
    return e;
  endfunction

  function automatic void push_code(input logic down, input logic [7:0] code);
    pending_codes.push_back('{is_down: down, keycode: code, last: 1'b0});
  endfunction

  // modifier prefixes in fixed order, then the key itself
  function automatic void push_key_sequence(input logic down, input logic [7:0] code,
                                            input logic [3:0] flags);
    if (flags[FLAG_SHIFT]) push_code(down, CODE_SHIFT);
    if (flags[FLAG_E0])    push_code(down, CODE_E0);
    if (flags[FLAG_ALT])   push_code(down, CODE_ALT);
    if (flags[FLAG_CTRL])  push_code(down, CODE_CTRL);
    push_code(down, code);
  endfunction

  function automatic void predict_scancodes(input logic [7:0] b);
    int unsigned queued_before;
    key_entry_t  e;
    queued_before = pending_codes.size();
    if (held_valid) begin
      push_key_sequence(1'b0, held_code, held_flags);
      held_valid = 1'b0;
      held_code  = '0;
      held_flags = '0;
      if (alt_on) begin
        alt_on = 1'b0;
        push_code(1'b0, CODE_ALT);
      end
      if (ctrl_on) begin
        ctrl_on = 1'b0;
        push_code(1'b0, CODE_CTRL);
      end
      if (shift_on) begin
        shift_on = 1'b0;
        push_code(1'b0, CODE_SHIFT);
      end
    end
    if (b == BYTE_ALT_TOGGLE) begin
      alt_on = ~alt_on;
      push_code(alt_on, CODE_ALT);
    end else if (b == BYTE_CTRL_TOGGLE) begin
      ctrl_on = ~ctrl_on;
      push_code(ctrl_on, CODE_CTRL);
    end else if (b == BYTE_SHIFT_TOGGLE) begin
      shift_on = ~shift_on;
      push_code(shift_on, CODE_SHIFT);
    end else if (b != BYTE_NONE) begin
      e = key_map(b);
      if (e.hit) begin
        push_key_sequence(1'b1, e.code, e.flags);
        held_valid = 1'b1;
        held_code  = e.code;
        held_flags = e.flags;
      end
    end
    if (pending_codes.size() > queued_before)
      pending_codes[pending_codes.size() - 1].last = 1'b1;
  endfunction

  function automatic logic [7:0] random_mapped_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (!key_map(b).hit);
    return b;
  endfunction

  // sender: bursts of back-to-back words with random gaps between them
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (sender_burst == 0) begin
      gap = $urandom_range(0, 6);
      sender_burst = $urandom_range(1, 12);
      if (gap != 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    sender_burst--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    key_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    predict_scancodes(b);
  endtask

  task automatic wait_codes_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk_i);
    sender_burst = 0;
  endtask

  task automatic test_single_keys();
    send_byte(BYTE_NONE);   // nothing held: no codes
    send_byte(8'h61);
    send_byte(8'h41);       // shifted key
    send_byte(8'hB5);       // E0-prefixed cursor key
    send_byte(8'h8D);       // alt-modified key
    send_byte(8'h8E);       // ctrl-modified key
    send_byte(BYTE_NONE);   // release only
  endtask

  task automatic test_sticky_modifiers();
    send_byte(BYTE_ALT_TOGGLE);
    send_byte(BYTE_ALT_TOGGLE);     // toggled back off
    send_byte(BYTE_CTRL_TOGGLE);
    send_byte(BYTE_SHIFT_TOGGLE);
    send_byte(BYTE_ALT_TOGGLE);
    send_byte(8'h8D);               // no held key, stickies survive
    send_byte(8'h41);               // longest word train: release, three clears, press
    send_byte(BYTE_CTRL_TOGGLE);    // toggle never becomes the held key
    send_byte(BYTE_SHIFT_TOGGLE);
    send_byte(BYTE_NONE);
    send_byte(8'hB6);
    send_byte(BYTE_ALT_TOGGLE);
    send_byte(BYTE_NONE);
    send_byte(BYTE_ALT_TOGGLE);
  endtask

  task automatic test_unmapped_bytes();
    send_byte(8'hFF);
    send_byte(8'h31);
    send_byte(8'h80);       // releases the held key, nothing pressed
    send_byte(8'h7F);
  endtask

  task automatic test_random_typing(input int unsigned count);
    logic [7:0]  b;
    int unsigned pick;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)      b = random_mapped_byte();
      else if (pick < 70) b = 8'(BYTE_ALT_TOGGLE + $urandom_range(0, 2));
      else if (pick < 85) b = BYTE_NONE;
      else                b = 8'($urandom_range(0, 255));
      send_byte(b);
    end
  endtask

  task automatic test_drain_pause();
    test_random_typing(6);
    wait_codes_drained();
    test_random_typing(6);
  endtask

  // receiver: stall pattern switches between always-ready, coin-flip and mostly-stalled
  always @(negedge clk_i) begin
    if (stall_phase == 0) begin
      stall_mode  <= $urandom_range(0, 2);
      stall_phase <= $urandom_range(8, 40);
    end else begin
      stall_phase <= stall_phase - 1;
    end
    case (stall_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= 1'($urandom_range(0, 1));
      default: out_ready_i <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    scancode_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_codes.size() == 0) begin
        $display("%0t: unexpected word is_down=%0b keycode=%02h last=%0b",
                 $time, is_down_o, keycode_o, last_o);
        error_count++;
      end else begin
        want = pending_codes.pop_front();
        if (is_down_o !== want.is_down) begin
          $display("%0t: is_down expected %0b got %0b", $time, want.is_down, is_down_o);
          error_count++;
        end
        if (keycode_o !== want.keycode) begin
          $display("%0t: keycode expected %02h got %02h", $time, want.keycode, keycode_o);
          error_count++;
        end
        if (last_o !== want.last) begin
          $display("%0t: last expected %0b got %0b", $time, want.last, last_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: watchdog expired, %0d words outstanding", $time, pending_codes.size());
        $display("FAIL key_byte_to_ps2_scancodes");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_single_keys();
    test_sticky_modifiers();
    test_unmapped_bytes();
    test_drain_pause();
    test_random_typing(73);

    wait_codes_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS key_byte_to_ps2_scancodes");
    end else begin
      $display("FAIL key_byte_to_ps2_scancodes");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/kbs_pkg.sv
rtl/kbs_front.sv
rtl/kbs_fifo.sv
rtl/kbs_back.sv
rtl/key_byte_to_ps2_scancodes.sv
tb/tb.sv
